[sv/c2s_pkg.sv]
// Shared widths, constants and types of the cube-to-sphere mapping unit.
package c2s_pkg;

    // Fixed-point format and word layout
    localparam int FRAC_BITS = 14;
    localparam int FIELD_W   = 16;
    localparam int N_LANES   = 3;
    localparam int TDATA_W   = N_LANES * FIELD_W;

    // Magnitude of a field (up to 2^15) and its square (up to 2^30)
    localparam int MAGIN_W = FIELD_W;
    localparam int SQ_W    = 2 * FIELD_W - 1;
    localparam int PROD_W  = 2 * SQ_W - 1;
    localparam int NEG_W   = SQ_W;

    // a^2*b^2 plus the rounding offset, then scaled down by 2^(2F)
    localparam int SUM_W = PROD_W + 1;
    localparam int Q_W   = SUM_W - 2 * FRAC_BITS;

    // Divide by three as a multiply by ceil(2^K/3), split into two halves
    localparam int DIV_K  = Q_W + 1;
    localparam int ML_W   = (Q_W + 1) / 2;
    localparam int MH_W   = Q_W - ML_W;
    localparam int FULL_W = 2 * Q_W;
    localparam int T_W    = Q_W - 1;
    localparam logic [63:0] DIV3_M = ((64'd1 << DIV_K) + 64'd2) / 64'd3;
    localparam logic [ML_W-1:0] M_LO = DIV3_M[ML_W-1:0];
    localparam logic [MH_W-1:0] M_HI = DIV3_M[Q_W-1:ML_W];
    localparam logic [SUM_W-1:0] RND3 = SUM_W'(3) << (2 * FRAC_BITS - 1);

    // Radicand and root
    localparam int POS_W  = ((2 * FRAC_BITS > T_W) ? 2 * FRAC_BITS : T_W) + 1;
    localparam int R_W    = POS_W + (POS_W % 2);
    localparam int ROOT_W = R_W / 2;
    localparam int S_W    = ROOT_W + 1;
    localparam logic [R_W:0] ONE2 = (R_W + 1)'(1) << (2 * FRAC_BITS);

    // Scaled magnitude and saturation
    localparam int MAG_W = MAGIN_W + S_W;
    localparam int RND_W = MAG_W + 1 - FRAC_BITS;
    localparam int LIM_W = FIELD_W + 1;
    localparam int LIM_HI_I = (FRAC_BITS >= FIELD_W - 1) ? 32767 : (1 << FRAC_BITS);
    localparam int LIM_LO_I = (FRAC_BITS >= FIELD_W - 1) ? 32768 : (1 << FRAC_BITS);
    localparam logic [LIM_W-1:0] LIM_HI = LIM_W'(LIM_HI_I);
    localparam logic [LIM_W-1:0] LIM_LO = LIM_W'(LIM_LO_I);
    localparam logic [MAG_W:0] RND_HALF = (MAG_W + 1)'(1) << (FRAC_BITS - 1);

    // Lane pipeline depth: six front stages, root stages, rounding, scaling
    localparam int N_LANE = ROOT_W + 8;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_lane_res;

endpackage

[sv/cube_to_sphere_map_unit.sv]
// Path (at 14 fraction bits): the edge that accepts a word loads the first of six front
// stages, then 17 root stages, round, scale and the output register follow, and
// o_m_axis_tvalid rises as the word enters the output register.
// Throughput: one vertex per cycle unless the skid word is held; the pipeline and its root unit never iterate.
// A two-entry output buffer (output word plus skid word) takes one more word while blocked.
// Reset (i_rst_n low at a clock edge, synchronous) clears only the valid flags; no state.
// Top level of the cube-to-sphere mapping unit.
module cube_to_sphere_map_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [c2s_pkg::TDATA_W-1:0]      i_s_axis_tdata,   // cube_x, cube_y, cube_z
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [c2s_pkg::TDATA_W-1:0]      o_m_axis_tdata    // sphere_x, sphere_y, sphere_z
);
    import c2s_pkg::*;

    // The whole lane pipeline moves as one; it halts only while the skid word is
    // occupied, so the output side never reaches the input ready combinationally.
    logic                       w_adv;
    logic [N_LANE-1:0]          r_vld;
    logic signed [FIELD_W-1:0]  w_x, w_y, w_z;
    t_lane_res                  w_res [N_LANES];

    assign w_x = i_s_axis_tdata[0*FIELD_W +: FIELD_W];
    assign w_y = i_s_axis_tdata[1*FIELD_W +: FIELD_W];
    assign w_z = i_s_axis_tdata[2*FIELD_W +: FIELD_W];

    assign o_s_axis_tready = w_adv;

    // Track which pipeline slots hold a vertex; a bubble enters when no word is offered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[N_LANE-2:0], i_s_axis_tvalid};
        end
    end

    // Each lane scales one coordinate by the root built from the other two.
    c2s_lane u_lane_x (
        .i_clk (i_clk),
        .i_adv (w_adv),
        .i_c   (w_x),
        .i_a   (w_y),
        .i_b   (w_z),
        .o_res (w_res[0])
    );

    c2s_lane u_lane_y (
        .i_clk (i_clk),
        .i_adv (w_adv),
        .i_c   (w_y),
        .i_a   (w_z),
        .i_b   (w_x),
        .o_res (w_res[1])
    );

    c2s_lane u_lane_z (
        .i_clk (i_clk),
        .i_adv (w_adv),
        .i_c   (w_z),
        .i_a   (w_x),
        .i_b   (w_y),
        .o_res (w_res[2])
    );

    // Round to the output format, saturate to plus or minus one, and hold the word.
    c2s_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (r_vld[N_LANE-1]),
        .i_res    (w_res),
        .o_adv    (w_adv),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata)
    );

endmodule

[sv/c2s_isqrt.sv]
// Pipelined digit-by-digit square root with floor root and remainder outputs.
module c2s_isqrt (
    input  logic                         i_clk,
    input  logic                         i_adv,
    input  logic [c2s_pkg::R_W-1:0]      i_rad,
    output logic [c2s_pkg::ROOT_W-1:0]   o_root,
    output logic [c2s_pkg::ROOT_W:0]     o_rem
);
    import c2s_pkg::*;

    logic [R_W-1:0]    r_rad  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [ROOT_W:0]   r_rem  [ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++) begin : g_stg
        logic [R_W-1:0]    w_rad_in;
        logic [ROOT_W-1:0] w_root_in;
        logic [ROOT_W:0]   w_rem_in;
        logic [ROOT_W+2:0] w_cur;
        logic [ROOT_W+2:0] w_trial;
        logic [R_W-1:0]    n_rad;
        logic [ROOT_W-1:0] n_root;
        logic [ROOT_W:0]   n_rem;

        if (j == 0) begin : g_first
            assign w_rad_in  = i_rad;
            assign w_root_in = '0;
            assign w_rem_in  = '0;
        end else begin : g_next
            assign w_rad_in  = r_rad[j-1];
            assign w_root_in = r_root[j-1];
            assign w_rem_in  = r_rem[j-1];
        end

        // bring down two radicand bits, try root digit one
        always_comb begin
            w_cur   = {w_rem_in, w_rad_in[R_W-1 -: 2]};
            w_trial = {1'b0, w_root_in, 2'b01};
            n_rad   = w_rad_in << 2;
            if (w_cur >= w_trial) begin
                n_rem  = (ROOT_W + 1)'(w_cur - w_trial);
                n_root = {w_root_in[ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = w_cur[ROOT_W:0];
                n_root = {w_root_in[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rad[j]  <= n_rad;
                r_root[j] <= n_root;
                r_rem[j]  <= n_rem;
            end
        end
    end

    assign o_root = r_root[ROOT_W-1];
    assign o_rem  = r_rem[ROOT_W-1];

endmodule

[sv/c2s_lane.sv]
// One coordinate lane: scale factor radicand, root and scaled magnitude.
module c2s_lane (
    input  logic                                  i_clk,
    input  logic                                  i_adv,
    input  logic signed [c2s_pkg::FIELD_W-1:0]    i_c,
    input  logic signed [c2s_pkg::FIELD_W-1:0]    i_a,
    input  logic signed [c2s_pkg::FIELD_W-1:0]    i_b,
    output c2s_pkg::t_lane_res                    o_res
);
    import c2s_pkg::*;

    function automatic logic [MAGIN_W-1:0] f_abs(input logic signed [FIELD_W-1:0] v);
        return v[FIELD_W-1] ? MAGIN_W'(-v) : MAGIN_W'(v);
    endfunction

    logic [MAGIN_W-1:0]      w_am, w_bm;
    logic [2*MAGIN_W-1:0]    w_a2, w_b2;
    logic [2*SQ_W-1:0]       w_prod;
    logic [NEG_W-1:0]        w_neg;
    logic [SUM_W-1:0]        w_sum;
    logic [Q_W+ML_W-1:0]     w_pl;
    logic [Q_W+MH_W-1:0]     w_ph;
    logic [FULL_W-1:0]       w_full;
    logic [R_W:0]            w_diff;
    logic [ROOT_W-1:0]       w_root;
    logic [ROOT_W:0]         w_rem;
    logic [MAG_W-1:0]        w_mag;

    logic [SQ_W-1:0]         r_a2, r_b2;
    logic [PROD_W-1:0]       r_prod;
    logic [NEG_W-1:0]        r_neg1, r_neg2, r_neg3, r_neg4;
    logic [Q_W-1:0]          r_q;
    logic [Q_W+ML_W-1:0]     r_pl;
    logic [Q_W+MH_W-1:0]     r_ph;
    logic [T_W-1:0]          r_t;
    logic [R_W-1:0]          r_r;
    logic [S_W-1:0]          r_s;
    logic [MAG_W-1:0]        r_mag;
    logic [MAGIN_W-1:0]      r_cmag [ROOT_W+7];
    logic                    r_sgn  [N_LANE];

    always_comb begin
        w_am   = f_abs(i_a);
        w_bm   = f_abs(i_b);
        w_a2   = w_am * w_am;
        w_b2   = w_bm * w_bm;
        w_prod = r_a2 * r_b2;
        w_neg  = {1'b0, r_a2[SQ_W-1:1]} + {1'b0, r_b2[SQ_W-1:1]};
        // round half up to Q(2F) folded ahead of the divide by three
        w_sum  = SUM_W'(r_prod) + RND3;
        w_pl   = r_q * M_LO;
        w_ph   = r_q * M_HI;
        w_full = FULL_W'(r_pl) + (FULL_W'(r_ph) << ML_W);
        // negative radicand clamps to zero
        w_diff = ONE2 + (R_W + 1)'(r_t) - (R_W + 1)'(r_neg4);
        w_mag  = r_cmag[ROOT_W+6] * r_s;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_a2   <= w_a2[SQ_W-1:0];
            r_b2   <= w_b2[SQ_W-1:0];
            r_prod <= w_prod[PROD_W-1:0];
            r_neg1 <= w_neg;
            r_q    <= w_sum[SUM_W-1:2*FRAC_BITS];
            r_neg2 <= r_neg1;
            r_pl   <= w_pl;
            r_ph   <= w_ph;
            r_neg3 <= r_neg2;
            r_t    <= w_full[FULL_W-1:DIV_K];
            r_neg4 <= r_neg3;
            r_r    <= w_diff[R_W] ? '0 : w_diff[R_W-1:0];
            // round the root to nearest
            r_s    <= S_W'(w_root) + S_W'(w_rem > (ROOT_W + 1)'(w_root));
            r_mag  <= w_mag;

            r_cmag[0] <= f_abs(i_c);
            for (int k = 1; k < ROOT_W + 7; k++) begin
                r_cmag[k] <= r_cmag[k-1];
            end
            r_sgn[0] <= i_c[FIELD_W-1];
            for (int k = 1; k < N_LANE; k++) begin
                r_sgn[k] <= r_sgn[k-1];
            end
        end
    end

    c2s_isqrt u_sqrt (
        .i_clk  (i_clk),
        .i_adv  (i_adv),
        .i_rad  (r_r),
        .o_root (w_root),
        .o_rem  (w_rem)
    );

    assign o_res.neg = r_sgn[N_LANE-1];
    assign o_res.mag = r_mag;

endmodule

[sv/c2s_merge.sv]
// Merge stage: round and saturate lane results, output register and skid word.
module c2s_merge (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_vld,
    input  c2s_pkg::t_lane_res               i_res [c2s_pkg::N_LANES],
    output logic                             o_adv,
    output logic                             o_tvalid,
    input  logic                             i_tready,
    output logic [c2s_pkg::TDATA_W-1:0]      o_tdata   // sphere_x, sphere_y, sphere_z
);
    import c2s_pkg::*;

    function automatic logic [FIELD_W-1:0] f_sat(input t_lane_res res);
        logic [MAG_W:0]     sum;
        logic [RND_W-1:0]   rnd;
        logic [LIM_W-1:0]   lim;
        logic [LIM_W-1:0]   mag;
        logic [LIM_W-1:0]   val;
        sum = {1'b0, res.mag} + RND_HALF;
        rnd = sum[MAG_W:FRAC_BITS];
        lim = res.neg ? LIM_LO : LIM_HI;
        mag = (rnd > RND_W'(lim)) ? lim : rnd[LIM_W-1:0];
        val = res.neg ? (LIM_W'(0) - mag) : mag;
        return val[FIELD_W-1:0];
    endfunction

    logic [TDATA_W-1:0] w_word;
    logic               w_push, w_take;
    logic               r_out_vld, n_out_vld;
    logic               r_skid_vld, n_skid_vld;
    logic [TDATA_W-1:0] r_out, n_out;
    logic [TDATA_W-1:0] r_skid, n_skid;

    always_comb begin
        for (int l = 0; l < N_LANES; l++) begin
            w_word[l*FIELD_W +: FIELD_W] = f_sat(i_res[l]);
        end
    end

    assign w_push = i_vld && !r_skid_vld;
    assign w_take = r_out_vld && i_tready;

    always_comb begin
        n_out_vld  = r_out_vld;
        n_skid_vld = r_skid_vld;
        n_out      = r_out;
        n_skid     = r_skid;
        if (r_skid_vld) begin
            if (w_take) begin
                n_out      = r_skid;
                n_skid_vld = 1'b0;
            end
        end else if (w_push) begin
            if (!r_out_vld || w_take) begin
                n_out     = w_word;
                n_out_vld = 1'b1;
            end else begin
                n_skid     = w_word;
                n_skid_vld = 1'b1;
            end
        end else if (w_take) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_adv    = !r_skid_vld;
    assign o_tvalid = r_out_vld;
    assign o_tdata  = r_out;

`ifndef NO_ASSERTIONS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid word held without an output word");

    a_blocked_push_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && r_out_vld && !i_tready) |=> r_skid_vld)
        else $error("word pushed into a blocked output was not parked");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && i_tready) |=> (r_out_vld && !r_skid_vld))
        else $error("skid word not moved out when output taken");

    a_skid_rise_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(r_out_vld && !i_tready && i_vld))
        else $error("skid filled without a blocked output");
`endif

endmodule
